>>> rtl/core/dtpq_pkg.sv
`default_nettype none
package dtpq_pkg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT
    } t_state;

    typedef enum logic [1:0] {
        OP_ENQ = 2'd0,
        OP_DEQ = 2'd1,
        OP_CLR = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        ST_ADDED    = 3'd0,
        ST_PROMOTED = 3'd1,
        ST_DUP      = 3'd2,
        ST_RANGE    = 3'd3,
        ST_FULL     = 3'd4,
        ST_POPPED   = 3'd5,
        ST_EMPTY    = 3'd6,
        ST_CLEARED  = 3'd7
    } t_status;

    localparam int          LIMIT_W     = 9;
    localparam logic [8:0]  LIMIT_RESET = 9'd256;

endpackage
`default_nettype wire

>>> rtl/core/dedup_two_priority_work_queue_core.sv
`default_nettype none
// Deduplicating two-class cell queue. Entries sit in one RAM in arrival order, so the
// oldest entry is always at address 0 and removal closes the gap by copying later
// entries down. A lookup scans the pending cells until it hits or runs to the end, and a
// removal then copies every later entry down by one. The worst case, a dequeue with no
// urgent cell, scans and then copies all pending cells, both through the single RAM read
// port that the scan and the copy sweep share. Clear and an out-of-range height finish
// without leaving the idle state.
// busy is high while a request is in progress; the result appears on the o_ ports
// for exactly one cycle with o_result_valid and cannot be held off.
module dedup_two_priority_work_queue_core #(
    parameter int QUEUE_SLOTS   = 256,
    parameter int COLUMN_HEIGHT = 256
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [1:0]                    i_op,
    input  wire logic signed [31:0]            i_cell_x,
    input  wire logic signed [31:0]            i_cell_y,
    input  wire logic signed [31:0]            i_cell_z,
    input  wire logic                          i_is_urgent,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [dtpq_pkg::LIMIT_W-1:0]  i_cfg_data,
    output logic                               o_result_valid,
    output logic [2:0]                         o_status,
    output logic signed [31:0]                 o_out_x,
    output logic [7:0]                         o_out_y,
    output logic signed [31:0]                 o_out_z,
    output logic                               o_out_urgent,
    output logic [8:0]                         o_pending_count
);
    import dtpq_pkg::*;

    localparam int AW = $clog2(QUEUE_SLOTS);
    localparam int CW = $clog2(QUEUE_SLOTS + 1);
    localparam int YW = $clog2(COLUMN_HEIGHT);
    localparam int EW = 65 + YW;

    t_state           r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [LIMIT_W-1:0] r_limit, n_limit;
    logic             r_deq, n_deq;
    logic [31:0]      r_x, n_x, r_z, n_z;
    logic [YW-1:0]    r_y, n_y;
    logic             r_urg, n_urg;
    logic [CW-1:0]    r_ridx, n_ridx;
    logic             r_pv, n_pv;
    logic [AW-1:0]    r_pidx, n_pidx;
    logic [EW-1:0]    r_first, n_first;
    logic             r_res_valid, n_res_valid;
    t_status          r_status, n_status;
    logic [31:0]      r_ox, n_ox, r_oz, n_oz;
    logic [7:0]       r_oy, n_oy;
    logic             r_ou, n_ou;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    logic [EW-1:0]    ram_wdata, rd;
    logic             rd_urg;
    logic [31:0]      rd_x, rd_z;
    logic [YW-1:0]    rd_y;
    logic [EW-1:0]    new_entry;
    logic             y_bad, issue, sweep_end, rd_match, hit, hit_stop, full;

    dtpq_ram #(.WIDTH(EW), .DEPTH(QUEUE_SLOTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rd)
    );

    assign rd_urg    = rd[EW-1];
    assign rd_x      = rd[YW+63:YW+32];
    assign rd_y      = rd[YW+31:32];
    assign rd_z      = rd[31:0];
    assign new_entry = {r_urg, r_x, r_y, r_z};

    assign y_bad     = i_cell_y[31] || ($unsigned(i_cell_y) >= 32'(COLUMN_HEIGHT));
    assign issue     = r_ridx < r_count;
    assign sweep_end = !r_pv && !issue;
    assign rd_match  = r_deq ? rd_urg : (rd_x == r_x && rd_y == r_y && rd_z == r_z);
    assign hit       = r_pv && rd_match;
    // duplicate that needs no move: not urgent, or already urgent
    assign hit_stop  = !r_deq && (!r_urg || rd_urg);
    assign full      = (32'(r_count) >= 32'(r_limit)) || (32'(r_count) >= 32'(QUEUE_SLOTS));

    assign busy            = (r_state != S_IDLE);
    assign o_cfg_ready     = (r_state == S_IDLE);
    assign o_result_valid  = r_res_valid;
    assign o_status        = r_status;
    assign o_out_x         = r_ox;
    assign o_out_y         = r_oy;
    assign o_out_z         = r_oz;
    assign o_out_urgent    = r_ou;
    assign o_pending_count = 9'(r_count);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_op == OP_CLR) begin
                        n_state = S_IDLE;
                    end else if (i_op == OP_ENQ && y_bad) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (hit) begin
                    n_state = hit_stop ? S_IDLE : S_SHIFT;
                end else if (sweep_end) begin
                    n_state = (r_deq && r_count != '0) ? S_SHIFT : S_IDLE;
                end
            end
            S_SHIFT: begin
                if (sweep_end) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_count     = r_count;
        n_limit     = r_limit;
        n_deq       = r_deq;
        n_x         = r_x;
        n_y         = r_y;
        n_z         = r_z;
        n_urg       = r_urg;
        n_ridx      = r_ridx;
        n_pv        = 1'b0;
        n_pidx      = r_pidx;
        n_first     = r_first;
        n_res_valid = 1'b0;
        n_status    = r_status;
        n_ox        = r_ox;
        n_oy        = r_oy;
        n_oz        = r_oz;
        n_ou        = r_ou;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = new_entry;
        ram_raddr   = r_ridx[AW-1:0];

        if (i_cfg_valid && o_cfg_ready) begin
            n_limit = i_cfg_data;
        end

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_x    = i_cell_x;
                    n_y    = i_cell_y[YW-1:0];
                    n_z    = i_cell_z;
                    n_urg  = i_is_urgent;
                    n_ridx = '0;
                    n_ox   = '0;
                    n_oy   = '0;
                    n_oz   = '0;
                    n_ou   = 1'b0;
                    n_deq  = 1'b1;
                    unique case (i_op)
                        OP_CLR: begin
                            n_count     = '0;
                            n_status    = ST_CLEARED;
                            n_res_valid = 1'b1;
                        end
                        OP_ENQ: begin
                            n_deq = 1'b0;
                            if (y_bad) begin
                                n_status    = ST_RANGE;
                                n_res_valid = 1'b1;
                            end
                        end
                        default: n_deq = 1'b1;
                    endcase
                end
            end
            S_SCAN: begin
                if (r_pv && r_pidx == '0) begin
                    n_first = rd;
                end
                if (issue && !hit) begin
                    n_ridx = r_ridx + 1'b1;
                    n_pv   = 1'b1;
                    n_pidx = r_ridx[AW-1:0];
                end
                if (hit) begin
                    if (r_deq) begin
                        n_ox   = rd_x;
                        n_oy   = 8'(rd_y);
                        n_oz   = rd_z;
                        n_ou   = 1'b1;
                        n_ridx = CW'(r_pidx) + 1'b1;
                    end else if (hit_stop) begin
                        n_status    = ST_DUP;
                        n_res_valid = 1'b1;
                    end else begin
                        n_ridx = CW'(r_pidx) + 1'b1;
                    end
                end else if (sweep_end) begin
                    if (r_deq) begin
                        if (r_count == '0) begin
                            n_status    = ST_EMPTY;
                            n_res_valid = 1'b1;
                        end else begin
                            // no urgent entry: oldest overall is at the head
                            n_ox   = r_first[YW+63:YW+32];
                            n_oy   = 8'(r_first[YW+31:32]);
                            n_oz   = r_first[31:0];
                            n_ou   = 1'b0;
                            n_ridx = CW'(1);
                        end
                    end else if (full) begin
                        n_status    = ST_FULL;
                        n_res_valid = 1'b1;
                    end else begin
                        ram_we      = 1'b1;
                        ram_waddr   = r_count[AW-1:0];
                        n_count     = r_count + 1'b1;
                        n_status    = ST_ADDED;
                        n_res_valid = 1'b1;
                    end
                end
            end
            S_SHIFT: begin
                if (issue) begin
                    n_ridx = r_ridx + 1'b1;
                    n_pv   = 1'b1;
                    n_pidx = r_ridx[AW-1:0];
                end
                if (r_pv) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_pidx - 1'b1;
                    ram_wdata = rd;
                end
                if (sweep_end) begin
                    if (r_deq) begin
                        n_count  = r_count - 1'b1;
                        n_status = ST_POPPED;
                    end else begin
                        // promoted cell goes to the tail as urgent
                        ram_we    = 1'b1;
                        ram_waddr = AW'(r_count - 1'b1);
                        n_status  = ST_PROMOTED;
                    end
                    n_res_valid = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_limit     <= LIMIT_RESET;
            r_pv        <= 1'b0;
            r_res_valid <= 1'b0;
            r_ridx      <= '0;
            r_deq       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_limit     <= n_limit;
            r_pv        <= n_pv;
            r_res_valid <= n_res_valid;
            r_ridx      <= n_ridx;
            r_deq       <= n_deq;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x      <= n_x;
        r_y      <= n_y;
        r_z      <= n_z;
        r_urg    <= n_urg;
        r_pidx   <= n_pidx;
        r_first  <= n_first;
        r_status <= n_status;
        r_ox     <= n_ox;
        r_oy     <= n_oy;
        r_oz     <= n_oz;
        r_ou     <= n_ou;
    end

endmodule
`default_nettype wire

>>> rtl/core/dtpq_ram.sv
`default_nettype none
module dtpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

>>> bench/tb_top.sv
`default_nettype none
module tb_top;
    import dtpq_pkg::*;

    // op three is decoded as a dequeue
    localparam logic [1:0] OP_THREE = 2'd3;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               urgent;
    } t_request;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] x;
        logic [7:0]         y;
        logic signed [31:0] z;
        logic               urgent;
        logic [8:0]         count;
    } t_outcome;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        urgent;
    } t_cell;

    logic        i_clk;
    logic        i_rst_n;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_op = OP_ENQ;
    logic signed [31:0] i_cell_x = '0, i_cell_y = '0, i_cell_z = '0;
    logic        i_is_urgent = 1'b0;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [8:0]  i_cfg_data;
    logic        o_result_valid;
    logic [2:0]  o_status;
    logic signed [31:0] o_out_x, o_out_z;
    logic [7:0]  o_out_y;
    logic        o_out_urgent;
    logic [8:0]  o_pending_count;

    dedup_two_priority_work_queue_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_op(i_op), .i_cell_x(i_cell_x), .i_cell_y(i_cell_y), .i_cell_z(i_cell_z),
        .i_is_urgent(i_is_urgent), .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data), .o_result_valid(o_result_valid), .o_status(o_status),
        .o_out_x(o_out_x), .o_out_y(o_out_y), .o_out_z(o_out_z),
        .o_out_urgent(o_out_urgent), .o_pending_count(o_pending_count)
    );

    // queue model: entries held in arrival order, oldest first
    t_cell    waiting_cells[$];
    int       limit_now;
    t_request pending_reqs[$];
    t_outcome expected_outcomes[$];
    int       idle_pct;
    int       errors = 0;
    int       accepted = 0;
    int       results_seen = 0;
    int       pops_seen = 0;
    bit       stim_done;

    function automatic t_outcome queue_apply(t_request r);
        t_outcome o;
        int hit, idx;
        t_cell c;
        o = '0;
        if (r.op == OP_CLR) begin
            waiting_cells.delete();
            o.status = ST_CLEARED;
        end else if (r.op == OP_ENQ) begin
            if (r.y < 0 || r.y >= 256) begin
                o.status = ST_RANGE;
            end else begin
                hit = -1;
                foreach (waiting_cells[i])
                    if (waiting_cells[i].x == r.x && waiting_cells[i].y == r.y &&
                        waiting_cells[i].z == r.z) hit = i;
                if (hit >= 0) begin
                    if (!r.urgent || waiting_cells[hit].urgent) begin
                        o.status = ST_DUP;
                    end else begin
                        c = waiting_cells[hit];
                        waiting_cells.delete(hit);
                        c.urgent = 1'b1;
                        waiting_cells.insert(waiting_cells.size(), c);
                        o.status = ST_PROMOTED;
                    end
                end else if (waiting_cells.size() >= limit_now ||
                             waiting_cells.size() >= 256) begin
                    o.status = ST_FULL;
                end else begin
                    c.x = r.x; c.y = r.y; c.z = r.z; c.urgent = r.urgent;
                    waiting_cells.insert(waiting_cells.size(), c);
                    o.status = ST_ADDED;
                end
            end
        end else begin
            // op three decodes as dequeue
            idx = -1;
            foreach (waiting_cells[i])
                if (idx < 0 && waiting_cells[i].urgent) idx = i;
            if (idx < 0 && waiting_cells.size() > 0) idx = 0;
            if (idx < 0) begin
                o.status = ST_EMPTY;
            end else begin
                c = waiting_cells[idx];
                waiting_cells.delete(idx);
                o.status = ST_POPPED;
                o.x = c.x; o.y = c.y[7:0]; o.z = c.z; o.urgent = c.urgent;
            end
        end
        o.count = 9'(waiting_cells.size());
        return o;
    endfunction

    function automatic t_request make_req(logic [1:0] op, logic [31:0] x, logic [31:0] y,
                                          logic [31:0] z, logic u);
        t_request r;
        r.op = op; r.x = x; r.y = y; r.z = z; r.urgent = u;
        return r;
    endfunction

    // small coordinate pool so duplicates and promotions happen often
    function automatic t_request rand_req(int enq_pct);
        t_request r;
        int k;
        k = $urandom_range(99);
        r.op = (k < enq_pct) ? OP_ENQ :
               (k < 97 ? OP_DEQ : ($urandom_range(1) ? OP_CLR : OP_THREE));
        r.x = $urandom_range(3); r.z = $urandom_range(3); r.y = $urandom_range(255);
        if ($urandom_range(1)) r.y = $urandom_range(3);
        r.urgent = $urandom_range(1);
        k = $urandom_range(19);
        if (k == 0) r.x = $urandom;
        if (k == 1) r.z = $urandom;
        if (k == 2) r.y = $urandom;
        if (k == 3) r.y = 32'sh7fff_ffff;
        if (k == 4) r.y = 32'sh8000_0000;
        return r;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !busy) begin
            accepted <= accepted + 1;
            if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
                {i_op, i_cell_x, i_cell_y, i_cell_z, i_is_urgent} <= pending_reqs[0];
                expected_outcomes.insert(expected_outcomes.size(),
                                         queue_apply(pending_reqs[0]));
                pending_reqs.delete(0);
            end else begin
                start <= 1'b0;
            end
        end else if (!start && pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
            {i_op, i_cell_x, i_cell_y, i_cell_z, i_is_urgent} <= pending_reqs[0];
            expected_outcomes.insert(expected_outcomes.size(), queue_apply(pending_reqs[0]));
            pending_reqs.delete(0);
            start <= 1'b1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_outcome e;
        if (i_rst_n && o_result_valid) begin
            results_seen <= results_seen + 1;
            if (expected_outcomes.size() == 0) begin
                $error("result with no request outstanding, status %0d", o_status);
                errors = errors + 1;
            end else begin
                e = expected_outcomes[0];
                expected_outcomes.delete(0);
                if (e.status == ST_POPPED) pops_seen <= pops_seen + 1;
                if (o_status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, o_status);
                    errors = errors + 1;
                end
                if (o_out_x !== e.x) begin
                    $error("out_x exp %0h got %0h", e.x, o_out_x);
                    errors = errors + 1;
                end
                if (o_out_y !== e.y) begin
                    $error("out_y exp %0h got %0h", e.y, o_out_y);
                    errors = errors + 1;
                end
                if (o_out_z !== e.z) begin
                    $error("out_z exp %0h got %0h", e.z, o_out_z);
                    errors = errors + 1;
                end
                if (o_out_urgent !== e.urgent) begin
                    $error("out_urgent exp %0d got %0d", e.urgent, o_out_urgent);
                    errors = errors + 1;
                end
                if (o_pending_count !== e.count) begin
                    $error("pending_count exp %0d got %0d", e.count, o_pending_count);
                    errors = errors + 1;
                end
            end
        end
    end

    task automatic drain();
        while (pending_reqs.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
        while (start || busy || expected_outcomes.size() > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_limit(int v);
        drain();
        i_cfg_data  <= v[8:0];
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        limit_now = v;
    endtask

    initial begin
        int limits[6];
        int idles[4];
        int n;
        limits = '{256, 0, 1, 3, 511, 40};
        idles  = '{0, 74, 0, 25};
        stim_done = 0; idle_pct = 0; limit_now = 256;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0; i_cfg_data = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, each op, promotion, dup, range, empty, op three
        pending_reqs.insert(pending_reqs.size(), make_req(OP_DEQ, 0, 0, 0, 0));
        pending_reqs.insert(pending_reqs.size(),
                            make_req(OP_ENQ, 32'h8000_0000, 255, 32'h7fff_ffff, 0));
        pending_reqs.insert(pending_reqs.size(),
                            make_req(OP_ENQ, 32'h7fff_ffff, 0, 32'h8000_0000, 0));
        pending_reqs.insert(pending_reqs.size(), make_req(OP_ENQ, 32'hffff_ffff, 256, 5, 1));
        pending_reqs.insert(pending_reqs.size(), make_req(OP_ENQ, 1, 32'hffff_ffff, 5, 1));
        pending_reqs.insert(pending_reqs.size(), make_req(OP_ENQ, 1, 32'h8000_0000, 5, 1));
        pending_reqs.insert(pending_reqs.size(),
                            make_req(OP_ENQ, 32'h8000_0000, 255, 32'h7fff_ffff, 0));
        pending_reqs.insert(pending_reqs.size(),
                            make_req(OP_ENQ, 32'h7fff_ffff, 0, 32'h8000_0000, 1));
        pending_reqs.insert(pending_reqs.size(),
                            make_req(OP_ENQ, 32'h7fff_ffff, 0, 32'h8000_0000, 1));
        pending_reqs.insert(pending_reqs.size(), make_req(OP_ENQ, 9, 128, 9, 1));
        pending_reqs.insert(pending_reqs.size(), make_req(OP_THREE, 0, 0, 0, 0));
        pending_reqs.insert(pending_reqs.size(), make_req(OP_DEQ, 0, 0, 0, 0));
        pending_reqs.insert(pending_reqs.size(), make_req(OP_DEQ, 0, 0, 0, 0));
        pending_reqs.insert(pending_reqs.size(), make_req(OP_DEQ, 0, 0, 0, 0));
        pending_reqs.insert(pending_reqs.size(), make_req(OP_ENQ, 3, 7, 3, 0));
        pending_reqs.insert(pending_reqs.size(), make_req(OP_CLR, 0, 0, 0, 0));
        pending_reqs.insert(pending_reqs.size(), make_req(OP_DEQ, 0, 0, 0, 0));
        // the sender holds off here until everything has come back
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            set_limit(limits[ph]);
            idle_pct = idles[ph % 4];
            n = (ph == 4) ? 400 : 170;
            for (int i = 0; i < n; i++) begin
                // alternate filling and draining stretches
                pending_reqs.insert(pending_reqs.size(),
                                    rand_req(((i / 60) % 2) ? 30 : 75));
                if (ph == 4 && i == 300)
                    for (int j = 0; j < 260; j++)
                        pending_reqs.insert(pending_reqs.size(),
                                            make_req(OP_ENQ, j, j % 256, $urandom, 0));
            end
        end
        drain();
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        $display("Ran %0d requests over six limit settings and four idle mixes.", accepted);
        $display("Checked %0d results, %0d of them pops.", results_seen, pops_seen);
        if (errors == 0)
            $display("[dedup_two_priority_work_queue_core] OK");
        else
            $display("[dedup_two_priority_work_queue_core] ERROR");
        $finish;
    end

    initial begin
        #20000000;
        $display("[dedup_two_priority_work_queue_core] ERROR");
        $finish;
    end

endmodule
`default_nettype wire

>>> dedup_two_priority_work_queue_core.f
rtl/core/dtpq_pkg.sv
rtl/core/dtpq_ram.sv
rtl/core/dedup_two_priority_work_queue_core.sv
bench/tb_top.sv
